@@ sv/ffa_pkg.sv @@
// Package: shared types, codes and constants of the first-fit allocator.
package ffa_pkg;

    localparam int MAX_BLOCKS_DEF   = 16;
    localparam int MEMORY_UNITS_DEF = 64;

    localparam int TAG_W    = 8;
    localparam int START_W  = 6;
    localparam int SIZE_W   = 7;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    localparam logic [SIZE_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOROOM   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_TOOLARGE = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_ZERO     = 3'd5;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
    } ffa_entry_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [TAG_W-1:0]    block_tag;
        logic [START_W-1:0]  block_start;
        logic [SIZE_W-1:0]   block_size;
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   free_units;
        logic                last;
    } ffa_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MODIFY,
        ST_FINAL
    } ffa_state_t;

    typedef enum logic [1:0] {
        MD_INS,
        MD_DEL,
        MD_CMP
    } ffa_mode_t;

endpackage

@@ sv/ffa_if.sv @@
// Interfaces: request, result and configuration channels of the allocator.
interface ffa_req_if;
    import ffa_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    modport source (output valid, output cmd, output tag, output size, input ready);
    modport sink   (input valid, input cmd, input tag, input size, output ready);
endinterface

interface ffa_res_if;
    import ffa_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    block_tag;
    logic [START_W-1:0]  block_start;
    logic [SIZE_W-1:0]   block_size;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   free_units;
    logic                last;
    modport source (output valid, output kind, output block_tag, output block_start,
                    output block_size, output status, output free_units, output last,
                    input ready);
    modport sink   (input valid, input kind, input block_tag, input block_start,
                    input block_size, input status, input free_units, input last,
                    output ready);
endinterface

interface ffa_cfg_if;
    import ffa_pkg::*;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] memory_limit;
    modport source (output valid, output memory_limit, input ready);
    modport sink   (input valid, input memory_limit, output ready);
endinterface

@@ sv/ffa_cell.sv @@
// One cell of the block table ring: holds one entry and loads its neighbor's.
module ffa_cell (
    input  logic               clk,
    input  logic               shift,
    input  ffa_pkg::ffa_entry_t d,
    output ffa_pkg::ffa_entry_t q
);
    import ffa_pkg::*;

    ffa_entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

@@ sv/first_fit_allocator_with_compaction.sv @@
// From request accept to the final result: a table scan through every cell, a decision state, a
// table update through every cell for a grant or a release, and the loading of the result; a
// reject skips the update. The update and the result load wait while a result is stalled.
// One request at a time; the next is accepted after the final result is loaded. Reset clears
// the block count, the controller and the output valid and sets the limit to 64; the table is
// not cleared.
module first_fit_allocator_with_compaction #(
    parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
    parameter int MEMORY_UNITS = ffa_pkg::MEMORY_UNITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    ffa_req_if.sink   req,
    ffa_res_if.source res,
    ffa_cfg_if.sink   cfg
);
    import ffa_pkg::*;

    localparam int KW = $clog2(MAX_BLOCKS + 1);
    localparam int UW = $clog2(MAX_BLOCKS * 128);
    localparam logic [KW-1:0] K_LAST = KW'(MAX_BLOCKS - 1);
    localparam logic [KW-1:0] K_FULL = KW'(MAX_BLOCKS);
    localparam logic [SIZE_W-1:0] LIM_MAX = SIZE_W'(MEMORY_UNITS);

    // Table ring: cell 0 is the head, the controller feeds the tail.
    ffa_entry_t q [MAX_BLOCKS];
    ffa_entry_t feed;
    ffa_entry_t head;
    ffa_entry_t nxt;
    logic       shift;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BLOCKS; gi++)
        begin : g_cell
            ffa_entry_t d;
            if (gi == MAX_BLOCKS - 1)
            begin : g_tail
                assign d = feed;
            end
            else
            begin : g_mid
                assign d = q[gi+1];
            end
            ffa_cell u_cell (.clk(clk), .shift(shift), .d(d), .q(q[gi]));
        end
        if (MAX_BLOCKS > 1)
        begin : g_nxt
            assign nxt = q[1];
        end
        else
        begin : g_nxt1
            assign nxt = q[0];
        end
    endgenerate

    assign head = q[0];

    // Control state.
    ffa_state_t        state_reg, state_next;
    logic [KW-1:0]     count_reg, count_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [SIZE_W-1:0] lim_reg;
    logic              out_valid_reg, out_valid_next;

    // Working registers.
    logic              cmd_reg, cmd_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] cursor_reg, cursor_next;
    logic              found_reg, found_next;
    logic [KW-1:0]     pos_reg, pos_next;
    logic [START_W-1:0] hstart_reg, hstart_next;
    logic [UW-1:0]     used_reg, used_next;
    logic              rfound_reg, rfound_next;
    logic [KW-1:0]     rpos_reg, rpos_next;
    ffa_entry_t        rent_reg, rent_next;
    ffa_entry_t        carry_reg, carry_next;
    logic [SIZE_W-1:0] ccur_reg, ccur_next;
    ffa_mode_t         mode_reg, mode_next;
    ffa_result_t       pend_reg, pend_next;
    ffa_result_t       out_reg, out_next;

    logic [SIZE_W-1:0] lim;
    logic              ocan;
    logic              in_table;
    logic [SIZE_W-1:0] ent_end;
    logic [SIZE_W:0]   fit_end;
    logic [UW-1:0]     used_after;
    logic [UW-1:0]     lim_u;
    logic [SIZE_W-1:0] free_now;
    logic [SIZE_W-1:0] free_after;
    logic              hole_ok;
    ffa_entry_t        new_ent;

    always_comb
    begin
        if (lim_reg == '0)
        begin
            lim = SIZE_W'(1);
        end
        else if (lim_reg > LIM_MAX)
        begin
            lim = LIM_MAX;
        end
        else
        begin
            lim = lim_reg;
        end
    end

    assign lim_u    = UW'(lim);
    assign ocan     = !out_valid_reg || res.ready;
    assign in_table = (k_reg < count_reg);
    assign ent_end  = SIZE_W'(head.start) + head.size;
    assign fit_end  = {1'b0, cursor_reg} + {1'b0, size_reg};
    assign free_now = (used_reg >= lim_u) ? '0 : SIZE_W'(lim_u - used_reg);
    assign hole_ok  = found_reg || (fit_end <= {1'b0, lim});
    assign new_ent  = '{tag: tag_reg, start: START_W'(ccur_reg), size: size_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        out_valid_next = res.ready ? 1'b0 : out_valid_reg;
        cmd_next       = cmd_reg;
        tag_next       = tag_reg;
        size_next      = size_reg;
        cursor_next    = cursor_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        hstart_next    = hstart_reg;
        used_next      = used_reg;
        rfound_next    = rfound_reg;
        rpos_next      = rpos_reg;
        rent_next      = rent_reg;
        carry_next     = carry_reg;
        ccur_next      = ccur_reg;
        mode_next      = mode_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        shift          = 1'b0;
        feed           = head;
        used_after     = used_reg;
        free_after     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.cmd;
                    tag_next    = req.tag;
                    size_next   = req.size;
                    cursor_next = '0;
                    found_next  = 1'b0;
                    used_next   = '0;
                    rfound_next = 1'b0;
                    k_next      = '0;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                shift = 1'b1;
                if (in_table)
                begin
                    used_next = used_reg + UW'(head.size);
                    if (!found_reg && (SIZE_W'(head.start) >= cursor_reg)
                        && ((SIZE_W'(head.start) - cursor_reg) >= size_reg)
                        && (fit_end <= {1'b0, lim}))
                    begin
                        found_next  = 1'b1;
                        pos_next    = k_reg;
                        hstart_next = START_W'(cursor_reg);
                    end
                    if (ent_end > cursor_reg)
                    begin
                        cursor_next = ent_end;
                    end
                    if (!rfound_reg && (head.tag == tag_reg))
                    begin
                        rfound_next = 1'b1;
                        rpos_next   = k_reg;
                        rent_next   = head;
                    end
                end
                if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end

            ST_DECIDE:
            begin
                k_next     = '0;
                ccur_next  = '0;
                state_next = ST_FINAL;
                pend_next  = '{kind: KIND_REJECT, block_tag: tag_reg, block_start: '0,
                              block_size: size_reg, status: STAT_OK, free_units: '0,
                              last: 1'b1};
                if (cmd_reg == CMD_RELEASE)
                begin
                    pend_next.block_size = '0;
                    if (rfound_reg)
                    begin
                        pend_next.kind        = KIND_RELEASE;
                        pend_next.block_start = rent_reg.start;
                        pend_next.block_size  = rent_reg.size;
                        used_after            = used_reg - UW'(rent_reg.size);
                        mode_next             = MD_DEL;
                        pos_next              = rpos_reg;
                        state_next            = ST_MODIFY;
                    end
                    else
                    begin
                        pend_next.status = STAT_UNKNOWN;
                    end
                end
                else if (size_reg == '0)
                begin
                    pend_next.status = STAT_ZERO;
                end
                else if (size_reg > lim)
                begin
                    pend_next.status = STAT_TOOLARGE;
                end
                else if (count_reg >= K_FULL)
                begin
                    pend_next.status = STAT_FULL;
                end
                else if (hole_ok)
                begin
                    pend_next.kind        = KIND_GRANT;
                    pend_next.block_start = found_reg ? hstart_reg : START_W'(cursor_reg);
                    pos_next              = found_reg ? pos_reg : count_reg;
                    ccur_next             = found_reg ? SIZE_W'(hstart_reg) : cursor_reg;
                    used_after            = used_reg + UW'(size_reg);
                    mode_next             = MD_INS;
                    state_next            = ST_MODIFY;
                end
                else if (free_now >= size_reg)
                begin
                    pend_next.kind = KIND_GRANT;
                    pos_next       = count_reg;
                    used_after     = used_reg + UW'(size_reg);
                    mode_next      = MD_CMP;
                    state_next     = ST_MODIFY;
                end
                else
                begin
                    pend_next.status = STAT_NOROOM;
                end
                free_after           = (used_after >= lim_u) ? '0
                                       : SIZE_W'(lim_u - used_after);
                pend_next.free_units = free_after;
            end

            ST_MODIFY:
            begin
                if (ocan)
                begin
                    shift      = 1'b1;
                    carry_next = head;
                    unique case (mode_reg)
                        MD_INS:
                        begin
                            if (k_reg == pos_reg)
                            begin
                                feed = new_ent;
                            end
                            else if (k_reg > pos_reg)
                            begin
                                feed = carry_reg;
                            end
                        end
                        MD_DEL:
                        begin
                            if (k_reg >= pos_reg)
                            begin
                                feed = nxt;
                            end
                        end
                        MD_CMP:
                        begin
                            if (in_table)
                            begin
                                feed.start = START_W'(ccur_reg);
                                ccur_next  = ccur_reg + head.size;
                                if (SIZE_W'(head.start) != ccur_reg)
                                begin
                                    out_next = '{kind: KIND_MOVE, block_tag: head.tag,
                                                 block_start: START_W'(ccur_reg),
                                                 block_size: head.size, status: STAT_OK,
                                                 free_units: pend_reg.free_units,
                                                 last: 1'b0};
                                    out_valid_next = 1'b1;
                                end
                            end
                            else if (k_reg == pos_reg)
                            begin
                                feed                  = new_ent;
                                pend_next.block_start = START_W'(ccur_reg);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (k_reg == K_LAST)
                    begin
                        k_next     = '0;
                        count_next = (mode_reg == MD_DEL) ? count_reg - KW'(1)
                                                          : count_reg + KW'(1);
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end

            ST_FINAL:
            begin
                if (ocan)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            lim_reg       <= LIMIT_RESET;
            mode_reg      <= MD_INS;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            if (cfg.valid)
            begin
                lim_reg <= cfg.memory_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        tag_reg    <= tag_next;
        size_reg   <= size_next;
        cursor_reg <= cursor_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        hstart_reg <= hstart_next;
        used_reg   <= used_next;
        rfound_reg <= rfound_next;
        rpos_reg   <= rpos_next;
        rent_reg   <= rent_next;
        carry_reg  <= carry_next;
        ccur_reg   <= ccur_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign cfg.ready       = 1'b1;
    assign res.valid       = out_valid_reg;
    assign res.kind        = out_reg.kind;
    assign res.block_tag   = out_reg.block_tag;
    assign res.block_start = out_reg.block_start;
    assign res.block_size  = out_reg.block_size;
    assign res.status      = out_reg.status;
    assign res.free_units  = out_reg.free_units;
    assign res.last        = out_reg.last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= K_FULL)
        else $error("block count exceeds table depth");

    a_not_last_is_move: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.last) |-> (res.kind == KIND_MOVE))
        else $error("non-final result that is not a relocation");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.kind == KIND_GRANT)) |-> (res.status == STAT_OK))
        else $error("grant with a failing status");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_SCAN && k_reg == '0))
        else $error("accepted request did not start a table scan");

endmodule

@@ tb/ffa_scoreboard.sv @@
// Scoreboard: tracks the allocator's block table and checks every result item.
package ffa_tb_pkg;
    import ffa_pkg::*;

    class ffa_scoreboard;
        ffa_entry_t  blocks[$];
        int          limit_reg;
        ffa_result_t pending[$];
        int          errors;
        int          grants, moves, rejects, releases;

        function new();
            limit_reg = 64;
            errors = 0;
            grants = 0;
            moves = 0;
            rejects = 0;
            releases = 0;
        endfunction

        function void set_limit(int v);
            limit_reg = v;
        endfunction

        function int active_limit();
            int m;
            m = limit_reg;
            if (m == 0) m = 1;
            if (m > MEMORY_UNITS_DEF) m = MEMORY_UNITS_DEF;
            return m;
        endfunction

        function int free_total();
            int u;
            u = 0;
            foreach (blocks[i]) u += blocks[i].size;
            return (u >= active_limit()) ? 0 : active_limit() - u;
        endfunction

        function void push(logic [KIND_W-1:0] k, int t, int s, int z,
                           logic [STATUS_W-1:0] st);
            ffa_result_t r;
            r = '0;
            r.kind = k;
            r.block_tag = TAG_W'(t);
            r.block_start = START_W'(s);
            r.block_size = SIZE_W'(z);
            r.status = st;
            pending.insert(pending.size(), r);
        endfunction

        // Notes one accepted request and queues the results it must produce.
        function void note_request(logic cmd, int tag, int size);
            int lim, cursor, pos, base, n, idx;
            bit found;
            ffa_entry_t e;
            base = pending.size();
            lim = active_limit();
            if (cmd == CMD_RELEASE) begin
                idx = -1;
                foreach (blocks[i]) if (idx < 0 && blocks[i].tag == tag) idx = i;
                if (idx < 0) push(KIND_REJECT, tag, 0, 0, STAT_UNKNOWN);
                else begin
                    push(KIND_RELEASE, tag, blocks[idx].start, blocks[idx].size, STAT_OK);
                    blocks.delete(idx);
                end
            end else if (size == 0) push(KIND_REJECT, tag, 0, size, STAT_ZERO);
            else if (size > lim) push(KIND_REJECT, tag, 0, size, STAT_TOOLARGE);
            else if (blocks.size() >= MAX_BLOCKS_DEF) push(KIND_REJECT, tag, 0, size, STAT_FULL);
            else begin
                cursor = 0;
                found = 0;
                pos = blocks.size();
                foreach (blocks[i]) begin
                    if (!found && blocks[i].start >= cursor
                        && blocks[i].start - cursor >= size && cursor + size <= lim) begin
                        found = 1;
                        pos = i;
                    end
                    if (!found && blocks[i].start + blocks[i].size > cursor)
                        cursor = blocks[i].start + blocks[i].size;
                end
                if (!found && cursor + size <= lim) found = 1;
                e.tag = TAG_W'(tag);
                e.size = SIZE_W'(size);
                if (found) begin
                    e.start = START_W'(cursor);
                    blocks.insert(pos, e);
                    push(KIND_GRANT, tag, cursor, size, STAT_OK);
                end else if (free_total() >= size) begin
                    // Slide every block down toward address zero.
                    cursor = 0;
                    foreach (blocks[i]) begin
                        if (blocks[i].start != cursor) begin
                            blocks[i].start = START_W'(cursor);
                            push(KIND_MOVE, blocks[i].tag, cursor, blocks[i].size, STAT_OK);
                        end
                        cursor += blocks[i].size;
                    end
                    e.start = START_W'(cursor);
                    blocks.insert(blocks.size(), e);
                    push(KIND_GRANT, tag, cursor, size, STAT_OK);
                end else push(KIND_REJECT, tag, 0, size, STAT_NOROOM);
            end
            n = pending.size();
            for (int i = base; i < n; i++) pending[i].free_units = SIZE_W'(free_total());
            pending[n-1].last = 1'b1;
        endfunction

        function void check_result(ffa_result_t got);
            ffa_result_t want;
            if (pending.size() == 0) begin
                $error("result item with nothing expected: kind %0d tag %0d",
                       got.kind, got.block_tag);
                errors++;
                return;
            end
            want = pending.pop_front();
            case (want.kind)
                KIND_GRANT:   grants++;
                KIND_MOVE:    moves++;
                KIND_REJECT:  rejects++;
                default:      releases++;
            endcase
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind); errors++;
            end
            if (got.block_tag !== want.block_tag) begin
                $error("block_tag: expected %0d, got %0d", want.block_tag, got.block_tag);
                errors++;
            end
            if (got.block_start !== want.block_start) begin
                $error("block_start: expected %0d, got %0d", want.block_start,
                       got.block_start);
                errors++;
            end
            if (got.block_size !== want.block_size) begin
                $error("block_size: expected %0d, got %0d", want.block_size, got.block_size);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status); errors++;
            end
            if (got.free_units !== want.free_units) begin
                $error("free_units: expected %0d, got %0d", want.free_units, got.free_units);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last); errors++;
            end
        endfunction
    endclass
endpackage

@@ tb/tb_top.sv @@
// Top-level testbench of the first-fit allocator with compaction.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ffa_pkg::*;
    import ffa_tb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   calm = 1'b0;
    int   items_sent = 0;
    ffa_scoreboard sb = new();

    ffa_req_if req_ch();
    ffa_res_if res_ch();
    ffa_cfg_if cfg_ch();

    first_fit_allocator_with_compaction dut (
        .clk(clk), .rst_n(rst_n), .req(req_ch.sink), .res(res_ch.source), .cfg(cfg_ch.sink)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ALLOC;
        req_ch.tag = '0;
        req_ch.size = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.memory_limit = '0;
        res_ch.ready = 1'b0;
    end

    // Result side: random stalls except during the calm stretch.
    always @(posedge clk)
    begin
        ffa_result_t r;
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                r.kind = res_ch.kind;
                r.block_tag = res_ch.block_tag;
                r.block_start = res_ch.block_start;
                r.block_size = res_ch.block_size;
                r.status = res_ch.status;
                r.free_units = res_ch.free_units;
                r.last = res_ch.last;
                sb.check_result(r);
            end
            res_ch.ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    task automatic send_request(logic cmd, int tag, int size);
        while (!calm && $urandom_range(99) < 9) @(posedge clk);
        req_ch.valid <= 1'b1;
        req_ch.cmd <= cmd;
        req_ch.tag <= TAG_W'(tag);
        req_ch.size <= SIZE_W'(size);
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(cmd, tag, size);
        items_sent++;
        req_ch.valid <= 1'b0;
        // The block is busy after an accept, so the extra wait before moving on costs nothing.
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_limit(int v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.memory_limit <= SIZE_W'(v);
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_limit(v);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(int count, int tag_span);
        int r;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 55)
                send_request(CMD_ALLOC, $urandom_range(tag_span),
                             ($urandom_range(9) == 0) ? $urandom_range(127)
                                                      : $urandom_range(1, 12));
            else if (r < 90 && sb.blocks.size() > 0)
                send_request(CMD_RELEASE,
                             sb.blocks[$urandom_range(sb.blocks.size() - 1)].tag, 0);
            else
                send_request(1'($urandom_range(1)), $urandom_range(255), $urandom_range(127));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: zero, oversize, fill, holes, compaction, unknown, duplicates.
        send_request(CMD_ALLOC, 8'hFF, 0);
        send_request(CMD_ALLOC, 8'h00, 127);
        send_request(CMD_ALLOC, 8'h01, 65);
        send_request(CMD_ALLOC, 8'h02, 10);
        send_request(CMD_ALLOC, 8'h03, 20);
        send_request(CMD_ALLOC, 8'h04, 10);
        send_request(CMD_ALLOC, 8'h03, 4);
        send_request(CMD_RELEASE, 8'h02, 0);
        send_request(CMD_RELEASE, 8'h04, 127);
        send_request(CMD_ALLOC, 8'h05, 5);
        send_request(CMD_ALLOC, 8'h06, 30);
        send_request(CMD_ALLOC, 8'h07, 40);
        send_request(CMD_RELEASE, 8'hAA, 0);
        send_request(CMD_RELEASE, 8'h03, 0);
        send_request(CMD_RELEASE, 8'h03, 0);
        for (int i = 0; i < 17; i++) send_request(CMD_ALLOC, 8'h80 + i, 1);
        write_limit(0);
        send_request(CMD_ALLOC, 8'h10, 1);
        send_request(CMD_ALLOC, 8'h11, 2);
        write_limit(127);
        for (int i = 0; i < 10; i++) send_request(CMD_RELEASE, 8'h80 + 2 * i, 0);
        send_request(CMD_ALLOC, 8'h12, 64);
        send_request(CMD_ALLOC, 8'h13, 8);
        // Random phases through several limits.
        write_limit(64);
        calm = 1'b1;
        random_phase(40, 15);
        calm = 1'b0;
        write_limit(20);
        random_phase(40, 255);
        // Sender holds off until the block has answered everything.
        while (sb.pending.size() != 0) @(posedge clk);
        write_limit(1);
        random_phase(20, 7);
        write_limit(64);
        random_phase(20, 31);
        write_limit(37);
        random_phase(40, 31);
        drain();
        $display("Sent %0d requests across limits 0..127: %0d grants, %0d moves, %0d rejects,",
                 items_sent, sb.grants, sb.moves, sb.rejects);
        $display("%0d releases, including compaction, full-table and limit-lowering cases.",
                 sb.releases);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Verification failed");
        $finish;
    end
endmodule

@@ first_fit_allocator_with_compaction.f @@
sv/ffa_pkg.sv
sv/ffa_if.sv
sv/ffa_cell.sv
sv/first_fit_allocator_with_compaction.sv
tb/ffa_scoreboard.sv
tb/tb_top.sv
